/* design/gbia_pkg.sv */
package gbia_pkg;

   // Default sizes
   localparam int MaxGroupsDefault = 16;
   localparam int GroupBitsDefault = 8192;
   localparam int WordBitsDefault  = 64;

   // Field widths
   localparam int IdW     = 18;
   localparam int PerW    = 14;
   localparam int GrpCntW = 5;
   localparam int KindW   = 2;
   localparam int StatW   = 2;
   localparam int CsrIdxW = 2;
   localparam int CsrDatW = 18;

   // Item kinds
   localparam logic [KindW-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KindW-1:0] KIND_FREE  = 2'd1;
   localparam logic [KindW-1:0] KIND_QUERY = 2'd2;
   localparam logic [KindW-1:0] KIND_MARK  = 2'd3;

   // Result status codes
   localparam logic [StatW-1:0] STAT_OK    = 2'd0;
   localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
   localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CSR_TOTAL = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_PER   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_GRPS  = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic latch_req;   // capture request, start division setup
      logic div_step;    // one restoring division step
      logic scan_init;   // reset scan position
      logic scan_issue;  // issue read for current scan word
      logic scan_eval;   // check returned word, advance
      logic rd_issue;    // read word for free/query/mark
      logic modify;      // write modified word, update count (query only samples the bit)
      logic grant;       // write allocated word, update count
      logic respond;     // drive result strobe
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic       div_done;
      logic       range_err;   // per==0, id==0, id>total
      logic       grp_err;     // quotient at or beyond group count
      logic       per_zero;
      logic       hit;         // scanned word has a clear bit in range
      logic       scan_end;    // last word of scan evaluated
      logic       clr_done;
      logic [1:0] kind;
   } dp_stat_type;

endpackage

/* design/gbia_ram.sv */
module gbia_ram #(
   parameter int Width = 64,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // One write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* design/gbia_ctrl.sv */
module gbia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  gbia_pkg::dp_stat_type st,
   output gbia_pkg::ctl_cmd_type cmd
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_RDW   = 4'd5;
   localparam logic [3:0] S_MOD   = 4'd6;
   localparam logic [3:0] S_SINIT = 4'd7;
   localparam logic [3:0] S_SISS  = 4'd8;
   localparam logic [3:0] S_SWAIT = 4'd9;
   localparam logic [3:0] S_SEVAL = 4'd10;
   localparam logic [3:0] S_GRANT = 4'd11;
   localparam logic [3:0] S_RESP  = 4'd12;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (st.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (st.kind == gbia_pkg::KIND_ALLOC) begin
               state_in = S_SINIT;
            end else if (st.div_done) begin
               state_in = S_CHK;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_CHK: begin
            if (st.range_err || st.grp_err) begin
               state_in = S_RESP;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RDW;
         end
         S_RDW: begin
            // hold the target address so the word stays on the read port
            cmd.rd_issue = 1'b1;
            state_in     = S_MOD;
         end
         S_MOD: begin
            cmd.modify = 1'b1;
            state_in   = S_RESP;
         end
         S_SINIT: begin
            cmd.scan_init = 1'b1;
            if (st.per_zero) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SISS;
            end
         end
         S_SISS: begin
            cmd.scan_issue = 1'b1;
            state_in       = S_SWAIT;
         end
         S_SWAIT: begin
            state_in = S_SEVAL;
         end
         S_SEVAL: begin
            cmd.scan_eval = 1'b1;
            if (st.hit) begin
               state_in = S_GRANT;
            end else if (st.scan_end) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SISS;
            end
         end
         S_GRANT: begin
            cmd.grant = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end
endmodule

/* design/gbia_dpath.sv */
module gbia_dpath #(
   parameter int MaxGroups = 16,
   parameter int GroupBits = 8192,
   parameter int WordBits  = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gbia_pkg::ctl_cmd_type               cmd,
   output gbia_pkg::dp_stat_type               st,
   input  logic [gbia_pkg::KindW-1:0]          req_kind,
   input  logic [gbia_pkg::IdW-1:0]            req_id_number,
   input  logic [gbia_pkg::IdW-1:0]            total_ids,
   input  logic [gbia_pkg::PerW-1:0]           ids_per_group,
   input  logic [gbia_pkg::GrpCntW-1:0]        group_count,
   output logic                                rsp_valid,
   output logic [gbia_pkg::StatW-1:0]          rsp_status,
   output logic [gbia_pkg::IdW-1:0]            rsp_granted_id,
   output logic                                rsp_in_use,
   output logic [gbia_pkg::IdW-1:0]            rsp_free_count
);
   localparam int IdW       = gbia_pkg::IdW;
   localparam int WordsPerG = (GroupBits + WordBits - 1) / WordBits;
   localparam int TotBits   = MaxGroups * GroupBits;
   localparam int Depth     = (TotBits + WordBits - 1) / WordBits;
   localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int BitW      = (WordBits > 1) ? $clog2(WordBits) : 1;
   localparam int PosW      = $clog2(TotBits) + 1;
   localparam int GBitW     = $clog2(GroupBits + 1);
   localparam int GIdxW     = $clog2(MaxGroups + 1);
   localparam int WIdxW     = $clog2(WordsPerG + 1);
   localparam int DivCntW   = $clog2(IdW + 1);
   localparam int CapW      = GIdxW + GBitW;

   // Effective sizes
   logic [GBitW-1:0] per_eff;
   logic [GIdxW-1:0] grp_eff;
   logic [CapW-1:0]  cap;
   assign per_eff = (32'(ids_per_group) > GroupBits) ? GBitW'(GroupBits)
                                                     : GBitW'(ids_per_group);
   assign grp_eff = (32'(group_count) > MaxGroups) ? GIdxW'(MaxGroups)
                                                   : GIdxW'(group_count);

   // Capacity is registered; config must only change while idle, which the block itself does not enforce
   logic [CapW-1:0] cap_ff;
   always_ff @(posedge clock) begin
      cap_ff <= CapW'(per_eff) * CapW'(grp_eff);
   end
   assign cap = cap_ff;

   // Request capture
   logic [1:0]     kind_ff;
   logic [IdW-1:0] id_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff <= req_kind;
         id_ff   <= req_id_number;
      end
   end

   // Restoring divider for (id-1) / per
   logic [IdW-1:0]     quo_ff, rem_ff, dvd_ff;
   logic [DivCntW-1:0] dcnt_ff;
   logic [IdW:0]       trial;
   assign trial = {rem_ff, dvd_ff[IdW-1]} - (IdW+1)'(per_eff);
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         dvd_ff  <= req_id_number - IdW'(1);
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[IdW-2:0], 1'b0};
         dcnt_ff <= dcnt_ff + DivCntW'(1);
         if (!trial[IdW]) begin
            rem_ff <= trial[IdW-1:0];
            quo_ff <= {quo_ff[IdW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[IdW-2:0], dvd_ff[IdW-1]};
            quo_ff <= {quo_ff[IdW-2:0], 1'b0};
         end
      end
   end

   // Bit position of the addressed id
   logic [PosW-1:0] tgt_pos;
   assign tgt_pos = PosW'(quo_ff[GIdxW-1:0]) * PosW'(GroupBits) + PosW'(rem_ff);

   // Scan position
   logic [GIdxW-1:0] sg_ff;
   logic [WIdxW-1:0] sw_ff;
   logic [PosW-1:0]  sbase;   // bit offset of scanned word within group
   logic [PosW-1:0]  spos;
   assign sbase = PosW'(sw_ff) * PosW'(WordBits);
   assign spos  = PosW'(sg_ff) * PosW'(GroupBits) + sbase;

   // Memory
   logic             wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [WordBits-1:0] wr_data, rd_data;
   logic             clr_ff;
   logic [AddrW-1:0] clr_addr_ff;

   gbia_ram #(.Width(WordBits), .Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = cmd.rd_issue ? AddrW'(tgt_pos / PosW'(WordBits))
                                 : AddrW'(spos / PosW'(WordBits));

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + AddrW'(1);
         if (32'(clr_addr_ff) == Depth - 1) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // Scan word evaluation: first clear bit below per_eff
   logic [WordBits-1:0] avail;
   logic                w_hit;
   logic [BitW-1:0]     w_bit;
   always_comb begin
      w_hit = 1'b0;
      w_bit = '0;
      for (int b = WordBits - 1; b >= 0; b--) begin
         avail[b] = !rd_data[b] && ((sbase + PosW'(b)) < PosW'(per_eff));
         if (avail[b]) begin
            w_hit = 1'b1;
            w_bit = BitW'(b);
         end
      end
   end

   logic [WordBits-1:0] word_ff;
   logic [AddrW-1:0]    waddr_ff;
   logic [BitW-1:0]     wbit_ff;
   logic [PosW-1:0]     goff_ff;
   logic [GIdxW-1:0]    ggrp_ff;
   logic                wlast;
   assign wlast = (sbase + PosW'(WordBits)) >= PosW'(per_eff);

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         sg_ff <= '0;
         sw_ff <= '0;
      end else if (cmd.scan_eval) begin
         word_ff  <= rd_data;
         waddr_ff <= AddrW'(spos / PosW'(WordBits));
         wbit_ff  <= w_bit;
         goff_ff  <= sbase + PosW'(w_bit);
         ggrp_ff  <= sg_ff;
         if (wlast) begin
            sw_ff <= '0;
            sg_ff <= sg_ff + GIdxW'(1);
         end else begin
            sw_ff <= sw_ff + WIdxW'(1);
         end
      end
   end

   // Grant id base: group index times group size
   logic [IdW-1:0] gid_base;
   assign gid_base = IdW'(32'(ggrp_ff) * 32'(per_eff));

   // Status; an empty map (no bits or no groups) skips the scan
   logic [IdW:0] used_ff;
   assign st.div_done  = (32'(dcnt_ff) == IdW);
   assign st.per_zero  = (per_eff == '0) || (grp_eff == '0);
   assign st.range_err = (per_eff == '0) || (id_ff == '0) || (id_ff > total_ids);
   assign st.grp_err   = (quo_ff >= IdW'(grp_eff));
   assign st.hit       = w_hit;
   assign st.scan_end  = wlast && ((sg_ff + GIdxW'(1)) >= grp_eff);
   assign st.clr_done  = !clr_ff;
   assign st.kind      = kind_ff;

   // Memory write and count update
   logic [BitW-1:0] tbit;
   assign tbit = BitW'(tgt_pos % PosW'(WordBits));
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AddrW'(tgt_pos / PosW'(WordBits));
      wr_data = rd_data;
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.grant) begin
         wr_en   = 1'b1;
         wr_addr = waddr_ff;
         wr_data = word_ff;
         wr_data[wbit_ff] = 1'b1;
      end else if (cmd.modify && kind_ff != gbia_pkg::KIND_QUERY) begin
         wr_en   = 1'b1;
         wr_data[tbit] = (kind_ff == gbia_pkg::KIND_MARK);
      end
   end

   // Response fields
   logic [1:0]     stat_ff;
   logic [IdW-1:0] gid_ff;
   logic           inuse_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.grant ||
                   (cmd.modify && kind_ff == gbia_pkg::KIND_MARK)) begin
         if ((IdW+1)'(used_ff) < (IdW+1)'(cap)) begin
            used_ff <= used_ff + (IdW+1)'(1);
         end
      end else if (cmd.modify && kind_ff == gbia_pkg::KIND_FREE) begin
         if (used_ff != '0) begin
            used_ff <= used_ff - (IdW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         stat_ff  <= gbia_pkg::STAT_OK;
         gid_ff   <= '0;
         inuse_ff <= 1'b0;
      end else begin
         if (cmd.scan_init && st.per_zero) begin
            stat_ff <= gbia_pkg::STAT_FULL;
         end
         if (cmd.scan_eval && !w_hit && st.scan_end) begin
            stat_ff <= gbia_pkg::STAT_FULL;
         end
         if (cmd.grant) begin
            gid_ff <= gid_base + IdW'(goff_ff) + IdW'(1);
         end
         if (cmd.modify && kind_ff == gbia_pkg::KIND_QUERY) begin
            inuse_ff <= rd_data[tbit];
         end
         if (kind_ff != gbia_pkg::KIND_ALLOC && !cmd.div_step && st.div_done &&
             (st.range_err || st.grp_err) && !cmd.modify) begin
            stat_ff <= gbia_pkg::STAT_RANGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.respond;
      end
      rsp_status     <= stat_ff;
      rsp_granted_id <= gid_ff;
      rsp_in_use     <= inuse_ff;
      rsp_free_count <= ((IdW+1)'(cap) > used_ff) ?
                        IdW'((IdW+1)'(cap) - used_ff) : '0;
   end
endmodule

/* design/grouped_bitmap_id_allocator_unit.sv */
// Channel  | Handshake              | Payload
// req      | start & !busy          | req_kind, req_id_number
// rsp      | rsp_valid, one cycle   | rsp_status, rsp_granted_id, rsp_in_use, rsp_free_count
// csr      | csr_valid & csr_ready  | csr_index, csr_data
//
// Free, query and mark hold busy while an 18-step serial divider finds the group,
// then for one read-modify-write, which a range error skips. Allocate holds busy
// while it scans bitmap words (issue the read, wait on the registered read port,
// evaluate) and then writes the granted bit, if any bit is free. The response strobe
// is registered and rises in the same cycle that busy drops. After reset the bitmap
// RAM is cleared one word per cycle with busy high. The receiver cannot stall a response.
module grouped_bitmap_id_allocator_unit #(
   parameter int MaxGroups = gbia_pkg::MaxGroupsDefault,
   parameter int GroupBits = gbia_pkg::GroupBitsDefault,
   parameter int WordBits  = gbia_pkg::WordBitsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gbia_pkg::KindW-1:0]         req_kind,
   input  logic [gbia_pkg::IdW-1:0]           req_id_number,
   output logic                               rsp_valid,
   output logic [gbia_pkg::StatW-1:0]         rsp_status,
   output logic [gbia_pkg::IdW-1:0]           rsp_granted_id,
   output logic                               rsp_in_use,
   output logic [gbia_pkg::IdW-1:0]           rsp_free_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbia_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [gbia_pkg::CsrDatW-1:0]       csr_data
);
   gbia_pkg::ctl_cmd_type cmd;
   gbia_pkg::dp_stat_type st;

   logic [gbia_pkg::IdW-1:0]     total_ff;
   logic [gbia_pkg::PerW-1:0]    per_ff;
   logic [gbia_pkg::GrpCntW-1:0] grps_ff;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= gbia_pkg::IdW'(131072);
         per_ff   <= gbia_pkg::PerW'(8192);
         grps_ff  <= gbia_pkg::GrpCntW'(16);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gbia_pkg::CSR_TOTAL: total_ff <= csr_data;
            gbia_pkg::CSR_PER:   per_ff   <= csr_data[gbia_pkg::PerW-1:0];
            gbia_pkg::CSR_GRPS:  grps_ff  <= csr_data[gbia_pkg::GrpCntW-1:0];
            default: ;
         endcase
      end
   end

   gbia_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   gbia_dpath #(
      .MaxGroups (MaxGroups),
      .GroupBits (GroupBits),
      .WordBits  (WordBits)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_kind       (req_kind),
      .req_id_number  (req_id_number),
      .total_ids      (total_ff),
      .ids_per_group  (per_ff),
      .group_count    (grps_ff),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .rsp_in_use     (rsp_in_use),
      .rsp_free_count (rsp_free_count)
   );

   // The response strobe is never high in consecutive cycles
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response strobe");
   // Busy holds while a response is produced
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy)) else $error("response without work");
   // No grant on a failed item
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != gbia_pkg::STAT_OK |-> rsp_granted_id == '0)
      else $error("grant on error");
endmodule
